// ===== hdl/ctb_pkg.sv =====
// Shared types and constants for the countdown timer bank.
`default_nettype none
package ctb_pkg;

  localparam int TIMER_SLOTS = 8;
  localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int COUNT_W     = 20;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  localparam logic EVT_DEC    = 1'b0;
  localparam logic EVT_EXPIRE = 1'b1;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [2:0]         timer_id;
    logic [COUNT_W-1:0] duration;
  } ctb_in_t;

  typedef struct packed {
    logic [2:0]         slot;
    logic               event_kind;
    logic [COUNT_W-1:0] count_left;
    logic               bank_idle;
    logic               last;
  } ctb_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC
  } ctb_state_t;

endpackage
`default_nettype wire

// ===== hdl/countdown_timer_bank.sv =====
// Top level: timer bank sequencer, active flags, count RAM and result register.
// Start and stop complete in idle; in_ready is high whenever no tick is being walked.
// A tick walks the active slots in order, a scan state (RAM read) then a calc state
// (update and write-back) per active slot; a tick with no active slot ends after the scan state.
// The first result is registered from the calc state after the scan; out stalls hold the walk.
// Reset clears all active flags at once; counts are not cleared (no clearing pass).
`default_nettype none
module countdown_timer_bank (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ctb_pkg::ctb_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ctb_pkg::ctb_out_t      out_data
);
  import ctb_pkg::*;

  ctb_state_t             state_r, state_nxt;
  logic [TIMER_SLOTS-1:0] active_r, active_nxt;
  logic [SLOT_W-1:0]      idx_r, idx_nxt;
  logic [SLOT_W-1:0]      cur_r, cur_nxt;
  logic                   any_left_r, any_left_nxt;
  logic                   out_valid_r, out_valid_nxt;
  ctb_out_t               out_r, out_nxt;

  logic                   ram_we;
  logic [SLOT_W-1:0]      ram_waddr, ram_raddr;
  logic [COUNT_W-1:0]     ram_wdata, ram_rdata;

  logic [TIMER_SLOTS-1:0] scan_mask, above_mask;
  logic                   found;
  logic [SLOT_W-1:0]      next_slot;
  logic                   in_fire, out_free, more, dec;
  logic [SLOT_W-1:0]      id_idx;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;
  assign id_idx    = SLOT_W'(in_data.timer_id);

  always_comb begin
    for (int j = 0; j < TIMER_SLOTS; j++) begin
      scan_mask[j]  = active_r[j] && (j >= int'(idx_r));
      above_mask[j] = active_r[j] && (j > int'(cur_r));
    end
    found     = |scan_mask;
    next_slot = '0;
    for (int j = TIMER_SLOTS - 1; j >= 0; j--) begin
      if (scan_mask[j]) begin
        next_slot = SLOT_W'(j);
      end
    end
  end

  assign more      = |above_mask;
  assign dec       = (ram_rdata != '0);
  assign ram_raddr = (state_r == ST_SCAN) ? next_slot : cur_r;

  ctb_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (TIMER_SLOTS)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    active_nxt    = active_r;
    idx_nxt       = idx_r;
    cur_nxt       = cur_r;
    any_left_nxt  = any_left_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = cur_r;
    ram_wdata     = ram_rdata - COUNT_W'(1);

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_data.cmd)
            CMD_TICK: begin
              state_nxt    = ST_SCAN;
              idx_nxt      = '0;
              any_left_nxt = 1'b0;
            end
            CMD_START: begin
              if (int'(in_data.timer_id) < TIMER_SLOTS) begin
                active_nxt[id_idx] = 1'b1;
                ram_we             = 1'b1;
                ram_waddr          = id_idx;
                ram_wdata          = in_data.duration;
              end
            end
            CMD_STOP: begin
              if (int'(in_data.timer_id) < TIMER_SLOTS) begin
                active_nxt[id_idx] = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (found) begin
          cur_nxt   = next_slot;
          state_nxt = ST_CALC;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CALC: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_nxt.slot   = 3'(cur_r);
          out_nxt.last   = !more;
          if (dec) begin
            ram_we             = 1'b1;
            out_nxt.event_kind = EVT_DEC;
            out_nxt.count_left = ram_wdata;
            any_left_nxt       = 1'b1;
          end else begin
            active_nxt[cur_r]  = 1'b0;
            out_nxt.event_kind = EVT_EXPIRE;
            out_nxt.count_left = '0;
          end
          out_nxt.bank_idle = !more && !(any_left_r || dec);
          if (more) begin
            idx_nxt   = cur_r + SLOT_W'(1);
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= '0;
      idx_r       <= '0;
      cur_r       <= '0;
      any_left_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      idx_r       <= idx_nxt;
      cur_r       <= cur_nxt;
      any_left_r  <= any_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule
`default_nettype wire

// ===== hdl/ctb_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module ctb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
